// File: hdl/bca_pkg.sv
package bca_pkg;

  localparam int unsigned BLK_W  = 16;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned MAXB_W = 13;

  localparam logic [BLK_W-1:0]  CHAIN_END        = 16'hFFFF;
  localparam logic [BLK_W-1:0]  FORMAT_LAST      = 16'd4;
  localparam logic [MAXB_W-1:0] RESET_MAX_BLOCKS = 13'd2048;

  typedef enum logic [1:0] {
    MODE_FORMAT = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_NEXT   = 2'd3
  } mode_e;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_CLEAR   = 11'b00000000010,
    S_CNT     = 11'b00000000100,
    S_SCAN    = 11'b00000001000,
    S_TAIL    = 11'b00000010000,
    S_WALK_RD = 11'b00000100000,
    S_WALK_WT = 11'b00001000000,
    S_FREE_RD = 11'b00010000000,
    S_FREE_WT = 11'b00100000000,
    S_LOOK    = 11'b01000000000,
    S_RESP    = 11'b10000000000
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] block;
    logic             ok;
    logic [CNT_W-1:0] free_count;
  } resp_t;

endpackage

// File: hdl/bca_ram.sv
module bca_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4091
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bca_ctrl.sv
module bca_ctrl import bca_pkg::*; #(
  parameter int unsigned MAP_ENTRIES     = 4091,
  parameter int unsigned RESERVED_BLOCKS = 5,
  parameter int unsigned AW              = $clog2(MAP_ENTRIES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [BLK_W-1:0]  first_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [MAXB_W-1:0] max_blocks_i,
  input  logic              out_take_i,
  output resp_t             resp_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [BLK_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [BLK_W-1:0]  ram_rdata_i
);

  localparam logic [BLK_W-1:0] RES        = BLK_W'(RESERVED_BLOCKS);
  localparam logic [BLK_W-1:0] MAP_N      = BLK_W'(MAP_ENTRIES);
  localparam logic [BLK_W-1:0] TOP_BLK    = BLK_W'(MAP_ENTRIES - RESERVED_BLOCKS);
  localparam logic [AW-1:0]    CLR_LAST   = AW'(MAP_ENTRIES - 1);
  localparam logic [BLK_W-1:0] RESET_FREE = BLK_W'(RESET_MAX_BLOCKS) - RES;

  state_e           state_q, state_d;
  logic [BLK_W-1:0] ptr_q, ptr_d, left_q, left_d, rblk_q, rblk_d, zeros_q, zeros_d;
  logic [BLK_W-1:0] prev_q, prev_d, first_q, first_d, b_q, b_d;
  logic [BLK_W-1:0] free_q, free_d, last_q, last_d, res_blk_q, res_blk_d;
  logic [CNT_W-1:0] n_q, n_d, cnt_q, cnt_d, len_q, len_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             rv_q, rv_d, fmt_q, fmt_d, res_ok_q, res_ok_d;

  logic [BLK_W-1:0] lim_sub, lim, win, s0, s1, start, ptr_inc, ptr_nx;
  logic [BLK_W:0]   free_sum;
  logic             issue, hit;

  function automatic logic [AW-1:0] to_addr(input logic [BLK_W-1:0] b);
    logic [BLK_W-1:0] d;
    d = b - RES;
    return d[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [BLK_W-1:0] b);
    return (b >= RES) && (b <= TOP_BLK);
  endfunction

  always_comb begin
    lim_sub = ({3'b0, max_blocks_i} >= RES) ? ({3'b0, max_blocks_i} - RES) : '0;
    lim     = (lim_sub > MAP_N) ? MAP_N : lim_sub;
    win     = (lim > RES) ? (lim - RES) : '0;
    s0      = last_q + 16'd1;
    s1      = (s0 < RES) ? RES : s0;
    start   = (s1 >= lim) ? RES : s1;
    ptr_inc = ptr_q + 16'd1;
    ptr_nx  = (ptr_inc >= lim) ? RES : ptr_inc;
    issue   = (left_q != '0);
    hit     = rv_q && (ram_rdata_i == '0);
    free_sum = {1'b0, free_q} + {5'b0, cnt_q};
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    left_d    = left_q;
    rblk_d    = rblk_q;
    zeros_d   = zeros_q;
    prev_d    = prev_q;
    first_d   = first_q;
    b_d       = b_q;
    free_d    = free_q;
    last_d    = last_q;
    res_blk_d = res_blk_q;
    res_ok_d  = res_ok_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    clr_d     = clr_q;
    rv_d      = 1'b0;
    fmt_d     = fmt_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cnt_d   = count_i;
          first_d = first_i;
          case (mode_i)
            MODE_FORMAT: begin
              free_d  = lim_sub;
              last_d  = FORMAT_LAST;
              clr_d   = '0;
              fmt_d   = 1'b1;
              state_d = S_CLEAR;
            end
            MODE_ALLOC: begin
              n_d = '0;
              if (count_i == '0) begin
                if (free_q == '0) begin
                  res_blk_d = CHAIN_END;
                  res_ok_d  = 1'b0;
                  state_d   = S_RESP;
                end else begin
                  ptr_d   = start;
                  left_d  = win;
                  state_d = S_SCAN;
                end
              end else if ({4'b0, count_i} > free_q) begin
                res_blk_d = CHAIN_END;
                res_ok_d  = 1'b0;
                state_d   = S_RESP;
              end else begin
                ptr_d   = RES;
                left_d  = win;
                zeros_d = '0;
                state_d = S_CNT;
              end
            end
            MODE_FREE: begin
              b_d     = first_i;
              len_d   = '0;
              state_d = S_WALK_RD;
            end
            MODE_NEXT: begin
              if (in_range(first_i)) begin
                ram_raddr_o = to_addr(first_i);
                state_d     = S_LOOK;
              end else begin
                res_blk_d = '0;
                res_ok_d  = 1'b0;
                state_d   = S_RESP;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        if (clr_q == CLR_LAST) begin
          res_blk_d = '0;
          res_ok_d  = 1'b1;
          state_d   = fmt_q ? S_RESP : S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_CNT: begin
        if (issue) begin
          ram_raddr_o = to_addr(ptr_q);
          ptr_d       = ptr_inc;
          left_d      = left_q - 16'd1;
          rblk_d      = ptr_q;
          rv_d        = 1'b1;
        end
        if (hit) begin
          zeros_d = zeros_q + 16'd1;
        end
        if (!issue && !rv_q) begin
          if (zeros_q >= {4'b0, cnt_q}) begin
            ptr_d   = start;
            left_d  = win;
            state_d = S_SCAN;
          end else begin
            res_blk_d = CHAIN_END;
            res_ok_d  = 1'b0;
            state_d   = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          ram_raddr_o = to_addr(ptr_q);
          ptr_d       = ptr_nx;
          left_d      = left_q - 16'd1;
          rblk_d      = ptr_q;
          rv_d        = 1'b1;
        end
        if (hit) begin
          if (cnt_q == '0) begin
            res_blk_d = rblk_q;
            res_ok_d  = 1'b1;
            rv_d      = 1'b0;
            state_d   = S_RESP;
          end else begin
            if (n_q != '0) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = to_addr(prev_q);
              ram_wdata_o = rblk_q;
            end else begin
              first_d = rblk_q;
            end
            prev_d = rblk_q;
            n_d    = n_q + CNT_W'(1);
            if (n_q + CNT_W'(1) == cnt_q) begin
              last_d  = rblk_q;
              rv_d    = 1'b0;
              state_d = S_TAIL;
            end
          end
        end else if (!issue && !rv_q) begin
          res_blk_d = CHAIN_END;
          res_ok_d  = 1'b0;
          state_d   = S_RESP;
        end
      end
      S_TAIL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = to_addr(prev_q);
        ram_wdata_o = CHAIN_END;
        free_d      = free_q - {4'b0, cnt_q};
        res_blk_d   = first_q;
        res_ok_d    = 1'b1;
        state_d     = S_RESP;
      end
      S_WALK_RD: begin
        if (b_q == CHAIN_END || b_q == '0) begin
          if (b_q == CHAIN_END && len_q == cnt_q) begin
            b_d     = first_q;
            state_d = S_FREE_RD;
          end else begin
            res_blk_d = '0;
            res_ok_d  = 1'b0;
            state_d   = S_RESP;
          end
        end else if (len_q >= cnt_q) begin
          res_blk_d = '0;
          res_ok_d  = 1'b0;
          state_d   = S_RESP;
        end else begin
          len_d = len_q + CNT_W'(1);
          if (in_range(b_q)) begin
            ram_raddr_o = to_addr(b_q);
            state_d     = S_WALK_WT;
          end else begin
            b_d = '0;
          end
        end
      end
      S_WALK_WT: begin
        b_d     = ram_rdata_i;
        state_d = S_WALK_RD;
      end
      S_FREE_RD: begin
        if (b_q == CHAIN_END) begin
          free_d    = free_sum[BLK_W] ? CHAIN_END : free_sum[BLK_W-1:0];
          res_blk_d = '0;
          res_ok_d  = 1'b1;
          state_d   = S_RESP;
        end else begin
          ram_raddr_o = to_addr(b_q);
          state_d     = S_FREE_WT;
        end
      end
      S_FREE_WT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = to_addr(b_q);
        b_d         = ram_rdata_i;
        state_d     = S_FREE_RD;
      end
      S_LOOK: begin
        res_blk_d = ram_rdata_i;
        res_ok_d  = 1'b1;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (out_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ptr_q     <= '0;
      left_q    <= '0;
      rblk_q    <= '0;
      zeros_q   <= '0;
      prev_q    <= '0;
      first_q   <= '0;
      b_q       <= '0;
      free_q    <= RESET_FREE;
      last_q    <= FORMAT_LAST;
      res_blk_q <= '0;
      res_ok_q  <= 1'b0;
      n_q       <= '0;
      cnt_q     <= '0;
      len_q     <= '0;
      clr_q     <= '0;
      rv_q      <= 1'b0;
      fmt_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      left_q    <= left_d;
      rblk_q    <= rblk_d;
      zeros_q   <= zeros_d;
      prev_q    <= prev_d;
      first_q   <= first_d;
      b_q       <= b_d;
      free_q    <= free_d;
      last_q    <= last_d;
      res_blk_q <= res_blk_d;
      res_ok_q  <= res_ok_d;
      n_q       <= n_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      clr_q     <= clr_d;
      rv_q      <= rv_d;
      fmt_q     <= fmt_d;
    end
  end

  assign resp_o.valid      = (state_q == S_RESP);
  assign resp_o.block      = res_blk_q;
  assign resp_o.ok         = res_ok_q;
  assign resp_o.free_count = (free_q > 16'h0FFF) ? 12'hFFF : free_q[CNT_W-1:0];

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("item accepted but control stayed idle");
  a_scan_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cnt_q != '0) |-> (n_q < cnt_q))
    else $error("allocation linked more blocks than requested");
  a_walk_keeps_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_RD) |=> $stable(free_q))
    else $error("free count changed during chain check");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESP || state_q == S_LOOK) |-> !ram_we_o)
    else $error("map written outside an update");
`endif

endmodule

// File: hdl/block_chain_allocator_top.sv
// block allocation table with chained next-fit allocation
// input items arrive on the s_axis channel: mode, first_block and count packed in tdata;
// one result item per input leaves on m_axis: block, ok and free_count packed in tdata.
// max_blocks is written through cfg_we_i / cfg_wdata_i; the user writes it only while no
// item is in progress, which the block itself does not enforce. the link table sits in a
// single ram with one write and one registered read port; an item is taken only while no
// earlier item is still being worked on. work per item, from acceptance to result ready:
//   next lookup: one ram read; format: one table entry cleared per cycle
//   allocate: the window is scanned once to count free entries (skipped for a count of
//   zero) and once to link them, one ram read per cycle
//   free: each link a dependent ram read, the chain walked twice (check, then clear)
// after reset, all MAP_ENTRIES entries are cleared before the first item is taken.
// the result sits in an output register; while the receiver stalls, the next item can be
// taken and worked on, and its result waits until the register is emptied.
module block_chain_allocator_top import bca_pkg::*; #(
  parameter int unsigned MAP_ENTRIES     = 4091,
  parameter int unsigned RESERVED_BLOCKS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [31:0]       s_axis_tdata_i,  // mode[1:0], first_block[17:2], count[29:18]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [31:0]       m_axis_tdata_o,  // block[15:0], ok[16], free_count[28:17]
  input  logic              cfg_we_i,
  input  logic [MAXB_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAP_ENTRIES);

  logic [MAXB_W-1:0] max_q;
  logic              m_vld_q, m_vld_d;
  logic [28:0]       m_data_q;
  logic              take;
  resp_t             resp;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BLK_W-1:0]  ram_wdata, ram_rdata;

  assign take = !m_vld_q || m_axis_tready_i;

  bca_ctrl #(
    .MAP_ENTRIES     (MAP_ENTRIES),
    .RESERVED_BLOCKS (RESERVED_BLOCKS),
    .AW              (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .mode_i       (s_axis_tdata_i[1:0]),
    .first_i      (s_axis_tdata_i[17:2]),
    .count_i      (s_axis_tdata_i[29:18]),
    .max_blocks_i (max_q),
    .out_take_i   (take),
    .resp_o       (resp),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  bca_ram #(
    .WIDTH (BLK_W),
    .DEPTH (MAP_ENTRIES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_vld_d = (resp.valid && take) || (m_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= RESET_MAX_BLOCKS;
      m_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.valid && take) begin
      m_data_q <= {resp.free_count, resp.ok, resp.block};
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {3'b000, m_data_q};

endmodule
